@@ src/csb_pkg.sv @@
// Shared types and constants for the cross stencil blur stream core.
// Used by every module of the block; depends on nothing else.
package csb_pkg;

    localparam int MAX_LINE_DEF  = 2048;
    localparam int CFG_W         = 12;
    localparam int STRIDE_RESET  = 640;
    localparam int PIX_W         = 32;
    localparam int CH_W          = 8;
    localparam int LANES         = PIX_W / CH_W;
    localparam int SUM_W         = CH_W + 3;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             frame_start;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             first_of_frame;
    } out_item_t;

    // The five stencil taps of one pixel, already masked at frame edges.
    typedef struct packed {
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] down;
        logic [PIX_W-1:0] left;
        logic [PIX_W-1:0] right;
        logic [PIX_W-1:0] centre;
    } window_t;

    typedef struct packed {
        logic emit;
        logic first;
    } ctrl_t;

endpackage

@@ src/csb_lane.sv @@
// One byte channel of the five-point cross blur.
// Depends on csb_pkg for channel and sum widths.
module csb_lane
(
    input  logic [csb_pkg::CH_W-1:0] up,
    input  logic [csb_pkg::CH_W-1:0] down,
    input  logic [csb_pkg::CH_W-1:0] left,
    input  logic [csb_pkg::CH_W-1:0] right,
    input  logic [csb_pkg::CH_W-1:0] centre,
    output logic [csb_pkg::CH_W-1:0] result
);

    logic [csb_pkg::SUM_W-1:0] sum;

    // The largest sum is 2040, so the shifted result always fits a byte.
    assign sum = csb_pkg::SUM_W'(up) + csb_pkg::SUM_W'(down) + csb_pkg::SUM_W'(left)
               + csb_pkg::SUM_W'(right) + {1'b0, centre, 2'b00};

    assign result = sum[csb_pkg::SUM_W-1:3];

endmodule

@@ src/csb_history.sv @@
// Line history of the blur: original and blurred line rings, fill tracking
// and the registered stencil taps of the pixel in flight. Depends on csb_pkg.
module csb_history #(
    parameter  int MAX_LINE = csb_pkg::MAX_LINE_DEF,
    localparam int SW       = $clog2(MAX_LINE + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  csb_pkg::in_item_t         item,
    input  logic [SW-1:0]             stride,
    input  logic                      blur_we,
    input  logic [csb_pkg::PIX_W-1:0] blur_wdata,
    output csb_pkg::window_t          window,
    output csb_pkg::ctrl_t            ctrl
);

    localparam int ORIG_DEPTH = MAX_LINE + 2;
    localparam int OW         = $clog2(ORIG_DEPTH);
    localparam int BLUR_DEPTH = MAX_LINE;
    localparam int BW         = $clog2(BLUR_DEPTH);
    localparam int FILL_CAP   = 2 * MAX_LINE + 1;
    localparam int FW         = $clog2(FILL_CAP + 1);

    // Two copies of the original ring so that three taps can be read per cycle.
    logic [csb_pkg::PIX_W-1:0] orig_a_mem [ORIG_DEPTH];
    logic [csb_pkg::PIX_W-1:0] orig_b_mem [ORIG_DEPTH];
    logic [csb_pkg::PIX_W-1:0] blur_mem   [BLUR_DEPTH];

    logic [OW-1:0] wpos_reg, wpos_next;
    logic [BW-1:0] opos_reg, opos_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [BW-1:0] s1_bpos_reg;
    logic          s1_emit_reg, s1_first_reg, s1_up_ok_reg;
    logic [csb_pkg::PIX_W-1:0] right_reg, left_reg, centre_reg, up_reg, down_reg;

    logic [FW-1:0] s_plus1, s2_plus1;
    logic          emit_now, first_now, up_ok_now;
    logic [OW-1:0] right_addr, centre_addr, left_addr;
    logic [BW-1:0] up_addr;

    function automatic logic [OW-1:0] orig_back(input logic [OW-1:0] pos,
                                                input logic [OW:0]   span);
        logic [OW:0] t;
        t = {1'b0, pos} + (OW+1)'(ORIG_DEPTH) - span;
        if (t >= (OW+1)'(ORIG_DEPTH))
            t = t - (OW+1)'(ORIG_DEPTH);
        return t[OW-1:0];
    endfunction

    function automatic logic [BW-1:0] blur_back(input logic [BW-1:0] pos,
                                                input logic [BW:0]   span);
        logic [BW:0] t;
        t = {1'b0, pos} + (BW+1)'(BLUR_DEPTH) - span;
        if (t >= (BW+1)'(BLUR_DEPTH))
            t = t - (BW+1)'(BLUR_DEPTH);
        return t[BW-1:0];
    endfunction

    always_comb
    begin
        if (item.frame_start)
            fill_next = FW'(1);
        else if (fill_reg < FW'(FILL_CAP))
            fill_next = fill_reg + FW'(1);
        else
            fill_next = fill_reg;

        s_plus1   = FW'(stride) + FW'(1);
        s2_plus1  = FW'(stride) + FW'(stride) + FW'(1);
        emit_now  = (fill_next >= s_plus1);
        first_now = (fill_next == s_plus1);
        up_ok_now = (fill_next >= s2_plus1);

        right_addr  = orig_back(wpos_reg, (OW+1)'(stride) - (OW+1)'(1));
        centre_addr = orig_back(wpos_reg, (OW+1)'(stride));
        left_addr   = orig_back(wpos_reg, (OW+1)'(stride) + (OW+1)'(1));
        up_addr     = blur_back(opos_reg, (BW+1)'(stride));

        if (wpos_reg == OW'(ORIG_DEPTH - 1))
            wpos_next = '0;
        else
            wpos_next = wpos_reg + OW'(1);

        if (!emit_now)
            opos_next = opos_reg;
        else if (opos_reg == BW'(BLUR_DEPTH - 1))
            opos_next = '0;
        else
            opos_next = opos_reg + BW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            orig_a_mem[wpos_reg] <= item.pixel_in;
            right_reg            <= orig_a_mem[right_addr];
            left_reg             <= orig_a_mem[left_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            orig_b_mem[wpos_reg] <= item.pixel_in;
            centre_reg           <= orig_b_mem[centre_addr];
        end
    end

    // The up tap is at least two results back, so it is written before it is read.
    always_ff @(posedge clk)
    begin
        if (accept)
            up_reg <= blur_mem[up_addr];
        if (blur_we)
            blur_mem[s1_bpos_reg] <= blur_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            down_reg    <= item.pixel_in;
            s1_bpos_reg <= opos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg     <= '0;
            opos_reg     <= '0;
            fill_reg     <= '0;
            s1_emit_reg  <= 1'b0;
            s1_first_reg <= 1'b0;
            s1_up_ok_reg <= 1'b0;
        end
        else if (accept)
        begin
            wpos_reg     <= wpos_next;
            opos_reg     <= opos_next;
            fill_reg     <= fill_next;
            s1_emit_reg  <= emit_now;
            s1_first_reg <= first_now;
            s1_up_ok_reg <= up_ok_now;
        end
    end

    always_comb
    begin
        window.up     = s1_up_ok_reg ? up_reg : '0;
        window.down   = down_reg;
        window.left   = s1_first_reg ? '0 : left_reg;
        window.right  = right_reg;
        window.centre = centre_reg;
        ctrl.emit     = s1_emit_reg;
        ctrl.first    = s1_first_reg;
    end

endmodule

@@ src/cross_stencil_blur_stream_core.sv @@
// Five-point cross blur over a raster pixel stream, filtered in place. The core
// takes one 32-bit pixel per clock and gives one result per clock, stalls aside,
// once a frame has filled: each result is the blurred pixel one line (line_stride
// pixels) earlier, released when its lower neighbour arrives, and leaves through
// the pixel stage and the output register. One pixel per clock holds because every
// line ring takes one write and at most two registered reads per cycle, and the
// four byte channels are computed by parallel lanes in the same cycle. An output
// stall holds off the input only once the pixel stage behind the output register
// is occupied. Line rings are not cleared after reset; the first pixel after reset
// starts a frame. line_stride is clamped to 2..MAX_LINE and must be written only
// by the user while no transaction is in flight; the core does not enforce it.
module cross_stencil_blur_stream_core #(
    parameter  int MAX_LINE = csb_pkg::MAX_LINE_DEF,
    localparam int SW       = $clog2(MAX_LINE + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pix_valid,
    output logic                      pix_stall,
    input  csb_pkg::in_item_t         pix_data,
    output logic                      res_valid,
    input  logic                      res_stall,
    output csb_pkg::out_item_t        res_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [csb_pkg::CFG_W-1:0] cfg_data
);

    localparam int STRIDE_RST = (csb_pkg::STRIDE_RESET > MAX_LINE) ?
                                MAX_LINE : csb_pkg::STRIDE_RESET;

    logic [SW-1:0]             stride_reg, stride_next;
    logic                      s1_valid_reg;
    logic                      res_valid_reg;
    csb_pkg::out_item_t        res_data_reg;
    logic                      advance, accept, blur_we;
    csb_pkg::window_t          window;
    csb_pkg::ctrl_t            ctrl;
    logic [csb_pkg::PIX_W-1:0] blurred;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (cfg_data < csb_pkg::CFG_W'(2))
            stride_next = SW'(2);
        else if (int'(cfg_data) > MAX_LINE)
            stride_next = SW'(MAX_LINE);
        else
            stride_next = SW'(cfg_data);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stride_reg <= SW'(STRIDE_RST);
        else if (cfg_valid && cfg_ready)
            stride_reg <= stride_next;
    end

    // The pixel in flight moves on whenever the output register is free or emptying.
    assign advance   = !res_valid_reg || !res_stall;
    assign pix_stall = s1_valid_reg && !advance;
    assign accept    = pix_valid && !pix_stall;
    assign blur_we   = s1_valid_reg && advance && ctrl.emit;

    csb_history #(
        .MAX_LINE (MAX_LINE)
    ) u_history (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item       (pix_data),
        .stride     (stride_reg),
        .blur_we    (blur_we),
        .blur_wdata (blurred),
        .window     (window),
        .ctrl       (ctrl)
    );

    for (genvar k = 0; k < csb_pkg::LANES; k++)
    begin : g_lane
        csb_lane u_lane (
            .up     (window.up    [k*csb_pkg::CH_W +: csb_pkg::CH_W]),
            .down   (window.down  [k*csb_pkg::CH_W +: csb_pkg::CH_W]),
            .left   (window.left  [k*csb_pkg::CH_W +: csb_pkg::CH_W]),
            .right  (window.right [k*csb_pkg::CH_W +: csb_pkg::CH_W]),
            .centre (window.centre[k*csb_pkg::CH_W +: csb_pkg::CH_W]),
            .result (blurred      [k*csb_pkg::CH_W +: csb_pkg::CH_W])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (blur_we)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // Merge the lane results into the output register.
    always_ff @(posedge clk)
    begin
        if (blur_we)
        begin
            res_data_reg.pixel_out      <= blurred;
            res_data_reg.first_of_frame <= ctrl.first;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

@@ src/csb_checker.sv @@
// Port-level checks for the cross stencil blur stream core, bound to its top.
// Depends on csb_pkg for the payload types.
module csb_checker
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pix_valid,
    input  logic                      pix_stall,
    input  csb_pkg::in_item_t         pix_data,
    input  logic                      res_valid,
    input  logic                      res_stall,
    input  csb_pkg::out_item_t        res_data
);

    // A stalled result keeps its valid and its payload.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("stalled result changed");

    // A stalled pixel transaction keeps its valid and its payload.
    a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_stall |=> pix_valid && $stable(pix_data))
        else $error("stalled pixel changed");

    // A new result follows a pixel transaction that passed through the pixel stage into the output register.
    a_res_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(pix_valid && !pix_stall, 2))
        else $error("result appeared without an accepted pixel");

    // The input is never held off while the output side can take a result.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!res_valid || !res_stall) |-> !pix_stall)
        else $error("input stalled while the output was free");

endmodule

bind cross_stencil_blur_stream_core csb_checker u_csb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_data  (pix_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);

@@ bench/cross_stencil_blur_stream_core_tb.sv @@
// Self-checking testbench for cross_stencil_blur_stream_core: random and directed pixel
// frames are checked against a cycle-free predictor of the in-place five-point blur.
// Depends on csb_pkg and the core; nothing else is read.
`timescale 1ns / 1ps

function automatic int unsigned clamp_stride(input int unsigned v);
    if (v < 2)
        return 2;
    if (v > csb_pkg::MAX_LINE_DEF)
        return csb_pkg::MAX_LINE_DEF;
    return v;
endfunction

function automatic logic [csb_pkg::PIX_W-1:0] rand_pixel();
    logic [31:0] m;
    m = $urandom();
    case ($urandom_range(9))
        0: return '0;
        1: return '1;
        2: return {{8{m[0]}}, {8{m[1]}}, {8{m[2]}}, {8{m[3]}}};
        default: return m;
    endcase
endfunction

// Predicts the blurred pixel stream and holds the results still owed by the core.
class cross_blur_predictor;
    localparam int ORIG_DEPTH = csb_pkg::MAX_LINE_DEF + 2;
    localparam int BLUR_DEPTH = csb_pkg::MAX_LINE_DEF;
    localparam int FILL_CAP   = 2 * csb_pkg::MAX_LINE_DEF + 1;

    logic [csb_pkg::PIX_W-1:0] orig_ring [ORIG_DEPTH];
    logic [csb_pkg::PIX_W-1:0] blur_ring [BLUR_DEPTH];
    int unsigned               stride_reg;
    int unsigned               fill_cnt;
    int unsigned               wr_pos;
    int unsigned               out_pos;
    csb_pkg::out_item_t        pending_blurs [$];
    int unsigned               mismatch_count;

    function void clear();
        foreach (orig_ring[i])
            orig_ring[i] = '0;
        foreach (blur_ring[i])
            blur_ring[i] = '0;
        stride_reg     = csb_pkg::STRIDE_RESET;
        fill_cnt       = 0;
        wr_pos         = 0;
        out_pos        = 0;
        mismatch_count = 0;
        pending_blurs.delete();
    endfunction

    function logic [csb_pkg::PIX_W-1:0] orig_at(input int unsigned back);
        return orig_ring[(wr_pos + ORIG_DEPTH - back) % ORIG_DEPTH];
    endfunction

    function void note_pixel(input csb_pkg::in_item_t item);
        int unsigned               s;
        int                        k;
        logic [csb_pkg::PIX_W-1:0] up;
        logic [csb_pkg::PIX_W-1:0] left;
        logic [csb_pkg::PIX_W-1:0] right;
        logic [csb_pkg::PIX_W-1:0] centre;
        logic [csb_pkg::PIX_W-1:0] blurred;
        logic [csb_pkg::SUM_W-1:0] sum;
        csb_pkg::out_item_t        owed;
        s = clamp_stride(stride_reg);
        if (item.frame_start)
            fill_cnt = 0;
        if (fill_cnt < FILL_CAP)
            fill_cnt++;
        orig_ring[wr_pos] = item.pixel_in;
        // The pixel one line back is released now that its lower neighbour is here.
        if (fill_cnt >= s + 1) begin
            left   = (fill_cnt == s + 1) ? '0 : orig_at(s + 1);
            up     = (fill_cnt >= 2 * s + 1) ? blur_ring[(out_pos + BLUR_DEPTH - s) % BLUR_DEPTH]
                                             : '0;
            right  = orig_at(s - 1);
            centre = orig_at(s);
            for (k = 0; k < csb_pkg::LANES; k++) begin
                sum = csb_pkg::SUM_W'(up[k*csb_pkg::CH_W +: csb_pkg::CH_W])
                    + csb_pkg::SUM_W'(item.pixel_in[k*csb_pkg::CH_W +: csb_pkg::CH_W])
                    + csb_pkg::SUM_W'(left[k*csb_pkg::CH_W +: csb_pkg::CH_W])
                    + csb_pkg::SUM_W'(right[k*csb_pkg::CH_W +: csb_pkg::CH_W])
                    + csb_pkg::SUM_W'({centre[k*csb_pkg::CH_W +: csb_pkg::CH_W], 2'b00});
                blurred[k*csb_pkg::CH_W +: csb_pkg::CH_W] = sum[csb_pkg::SUM_W-1:3];
            end
            blur_ring[out_pos]   = blurred;
            out_pos              = (out_pos + 1) % BLUR_DEPTH;
            owed.pixel_out       = blurred;
            owed.first_of_frame  = (fill_cnt == s + 1);
            pending_blurs.push_back(owed);
        end
        wr_pos = (wr_pos + 1) % ORIG_DEPTH;
    endfunction

    function void check_blurred(input csb_pkg::out_item_t got);
        csb_pkg::out_item_t owed;
        if (pending_blurs.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result: pixel %h first %b", got.pixel_out,
                         got.first_of_frame);
            return;
        end
        owed = pending_blurs.pop_front();
        if (got.pixel_out !== owed.pixel_out || got.first_of_frame !== owed.first_of_frame)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch: expected pixel %h first %b, got pixel %h first %b",
                         owed.pixel_out, owed.first_of_frame, got.pixel_out,
                         got.first_of_frame);
        end
    endfunction
endclass

module cross_stencil_blur_stream_core_tb;

    localparam int unsigned RANDOM_ITEMS = 470;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned SETTLE       = 8;
    localparam int unsigned HOLD_SEG     = 1;
    localparam int unsigned QUIET_SEG    = 2;
    localparam int unsigned EXTRA_LEN    = 150;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      pix_valid;
    logic                      pix_stall;
    csb_pkg::in_item_t         pix_data;
    logic                      res_valid;
    logic                      res_stall;
    csb_pkg::out_item_t        res_data;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [csb_pkg::CFG_W-1:0] cfg_data;

    cross_blur_predictor pred;
    bit                  no_idle;
    bit                  hold_req;
    int unsigned         quiet_cycles;

    cross_stencil_blur_stream_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Every transaction is seen here, at the rising edge, before the core updates.
    always @(posedge clk) begin
        if (rst_n) begin
            if (res_valid === 1'b1 && res_stall == 1'b0)
                pred.check_blurred(res_data);
            if (pix_valid && pix_stall === 1'b0)
                pred.note_pixel(pix_data);
            if (cfg_valid && cfg_ready === 1'b1)
                pred.stride_reg = cfg_data;
            if ((res_valid === 1'b1 && !res_stall) || (pix_valid && pix_stall === 1'b0)
                || (cfg_valid && cfg_ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Output side: random back-pressure, or one long hold-off on request.
    initial begin
        res_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                res_stall <= 1'b0;
            end else begin
                res_stall <= !no_idle && ($urandom_range(99) < 17);
            end
        end
    end

    task automatic send_pixel(input logic [csb_pkg::PIX_W-1:0] pix, input logic fs);
        @(negedge clk);
        if (!no_idle) begin
            while ($urandom_range(99) < 17) begin
                pix_valid <= 1'b0;
                @(negedge clk);
            end
        end
        pix_valid <= 1'b1;
        pix_data  <= '{pixel_in: pix, frame_start: fs};
        do
            @(posedge clk);
        while (pix_stall);
    endtask

    task automatic send_frame(input int unsigned count, input bit open_frame);
        int unsigned i;
        for (i = 0; i < count; i++)
            send_pixel(rand_pixel(), open_frame && (i == 0));
    endtask

    // Stop offering pixels and wait until every owed result has left the core.
    task automatic drain_results();
        @(negedge clk);
        pix_valid <= 1'b0;
        while (pred.pending_blurs.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_stride(input int unsigned v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v[csb_pkg::CFG_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned sent;
        int unsigned seg;
        int unsigned len;
        int unsigned s;
        int unsigned i;
        int unsigned pick;
        logic        fs;

        rst_n        = 1'b0;
        pix_valid    = 1'b0;
        pix_data     = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        no_idle      = 1'b0;
        hold_req     = 1'b0;
        quiet_cycles = 0;
        pred         = new();
        pred.clear();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // A stride of zero acts as two. The first pixel after reset opens a frame
        // even though its start flag is low.
        write_stride(0);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'h00FF_00FF, 1'b0);
        send_pixel(32'hFF00_FF00, 1'b0);
        send_pixel(32'h8080_8080, 1'b0);
        send_pixel(32'h7F7F_7F7F, 1'b0);
        send_pixel(32'h0102_0304, 1'b0);
        // A new frame drops what the old trailing line still owed.
        send_pixel(32'hFFFF_FFFF, 1'b1);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'h1234_5678, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        drain_results();

        write_stride(3);
        send_pixel(32'hFFFF_FFFF, 1'b1);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'hA5A5_A5A5, 1'b0);
        send_pixel(32'h5A5A_5A5A, 1'b0);
        drain_results();

        // An all-ones stride clamps to the widest line, so a short frame owes nothing.
        write_stride(12'hFFF);
        send_frame(20, 1'b1);
        drain_results();

        // Stride shrinks in the middle of a long frame.
        write_stride(12);
        send_frame(60, 1'b1);
        drain_results();
        write_stride(5);
        send_frame(30, 1'b0);
        drain_results();

        // Stride grows while the frame is still young.
        write_stride(3);
        send_frame(2, 1'b1);
        drain_results();
        write_stride(10);
        send_frame(40, 1'b0);
        drain_results();

        sent = 0;
        seg  = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(3) != 0) begin
                drain_results();
                pick = $urandom_range(99);
                if (pick < 5)
                    write_stride($urandom_range(1));
                else if (pick < 15)
                    write_stride($urandom_range(80, 17));
                else
                    write_stride($urandom_range(16, 2));
            end
            s   = clamp_stride(pred.stride_reg);
            len = s * $urandom_range(5, 2) + $urandom_range(s);
            if (seg == HOLD_SEG || seg == QUIET_SEG)
                len = len + EXTRA_LEN;
            no_idle = (seg == QUIET_SEG);
            for (i = 0; i < len; i++) begin
                // Most frames open with a start flag; a few carry a stray one inside.
                if (i == 0)
                    fs = ($urandom_range(4) != 0);
                else
                    fs = ($urandom_range(149) == 0);
                if (seg == HOLD_SEG && i == len / 2)
                    hold_req = 1'b1;
                send_pixel(rand_pixel(), fs);
            end
            no_idle = 1'b0;
            sent    = sent + len;
            seg++;
        end

        @(negedge clk);
        pix_valid <= 1'b0;
        while (pred.pending_blurs.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (pred.mismatch_count == 0 && pred.pending_blurs.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
